// ----- rtl/core/sets_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table package
// Shared constants, operation and status codes, controller states and the
// command group that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package sets_pkg;

    // Default geometry of the table.
    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_KIND_COUNT  = 8;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int TICK_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes carried in the op field.
    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_DEL_IDX = 3'd1,
        OP_DEL_KEY = 3'd2,
        OP_FIND    = 3'd3,
        OP_READ    = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_MARK = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // execute the operation on the accepted item
        logic mark;   // recompute the sync marks from the stored ticks
        logic load;   // move the staged result into the output register
    } t_cmd;

endpackage

// ----- rtl/core/sets_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table request channel
// Valid/ready channel carrying one table operation per transfer.
// ----------------------------------------------------------------------------
interface sets_in_if #(
    parameter int TABLE_DEPTH = sets_pkg::DEF_TABLE_DEPTH,
    parameter int KIND_COUNT  = sets_pkg::DEF_KIND_COUNT
);
    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int KW = $clog2(KIND_COUNT);

    logic                        valid;
    logic                        ready;
    logic [sets_pkg::OP_W-1:0]   op;
    logic [sets_pkg::TICK_W-1:0] event_tick;
    logic [KW-1:0]               event_kind;
    logic [SW-1:0]               slot;

    modport source (output valid, op, event_tick, event_kind, slot, input ready);
    modport sink   (input valid, op, event_tick, event_kind, slot, output ready);
endinterface

// ----- rtl/core/sets_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table result channel
// Valid/ready channel carrying one operation result per transfer.
// ----------------------------------------------------------------------------
interface sets_out_if #(
    parameter int TABLE_DEPTH = sets_pkg::DEF_TABLE_DEPTH,
    parameter int KIND_COUNT  = sets_pkg::DEF_KIND_COUNT
);
    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = $clog2(KIND_COUNT);

    logic                          valid;
    logic                          ready;
    logic [sets_pkg::STATUS_W-1:0] status;
    logic [SW-1:0]                 position;
    logic [CW-1:0]                 entry_count;
    logic [sets_pkg::TICK_W-1:0]   read_tick;
    logic [KW-1:0]                 read_kind;
    logic                          read_sync;

    modport source (output valid, status, position, entry_count, read_tick, read_kind,
                    read_sync, input ready);
    modport sink   (input valid, status, position, entry_count, read_tick, read_kind,
                    read_sync, output ready);
endinterface

// ----- rtl/core/sorted_event_table_with_sync_marks.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table with sync marks
// Keeps (tick, kind) entries sorted by tick with a sync mark per entry that
// is set when a neighboring entry has the same tick. Supports add, remove at
// index, remove by key, find and read; every result reports the count.
//
//   Channel  Dir  Payload                                     Transfer
//   i_in     in   op, event_tick, event_kind, slot            valid & ready
//   o_out    out  status, position, entry_count,              valid & ready
//                 read_tick, read_kind, read_sync
//
// An operation runs through the controller's idle and mark states: the transfer
// performs compare and shift in the entry cells, then the mark state refreshes
// the sync marks from the neighbor tick compares and loads the output register.
// One operation is in flight at a time; a new request is taken while a
// finished result still waits in the output register.
// A blocked output holds the controller in its mark cycle.
// Reset clears the entry count and the handshake state; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_event_table_with_sync_marks #(
    parameter int TABLE_DEPTH = sets_pkg::DEF_TABLE_DEPTH,
    parameter int KIND_COUNT  = sets_pkg::DEF_KIND_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sets_in_if.sink    i_in,
    sets_out_if.source o_out
);

    sets_pkg::t_cmd cmd;
    logic           in_ready;
    logic           out_valid;

    // Sequencer.
    sets_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Entry cells and result path.
    sets_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KIND_COUNT  (KIND_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_in.op),
        .i_tick        (i_in.event_tick),
        .i_kind        (i_in.event_kind),
        .i_slot        (i_in.slot),
        .o_status      (o_out.status),
        .o_position    (o_out.position),
        .o_entry_count (o_out.entry_count),
        .o_read_tick   (o_out.read_tick),
        .o_read_kind   (o_out.read_kind),
        .o_read_sync   (o_out.read_sync)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ----- rtl/core/sets_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table controller
// Two-state sequencer: executes an accepted operation, then refreshes the
// sync marks and hands the result to the output register when it is free.
// ----------------------------------------------------------------------------
module sets_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output sets_pkg::t_cmd o_cmd
);

    sets_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    sets_pkg::t_cmd   cmd;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sets_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        cmd        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sets_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.exec = 1'b1;
                    n_state  = sets_pkg::S_MARK;
                end
            end
            sets_pkg::S_MARK: begin
                cmd.mark = 1'b1;
                // Wait until the previous result has been taken.
                if (!r_out_valid || i_out_ready) begin
                    cmd.load = 1'b1;
                    n_state  = sets_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sets_pkg::S_IDLE;
            end
        endcase
        n_out_valid = cmd.load | (r_out_valid & ~i_out_ready);
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_exec_to_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> (r_state == sets_pkg::S_MARK))
        else $error("Executed operation did not move to the mark state.");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> r_out_valid)
        else $error("Loaded result is not presented as valid.");
    a_hold_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sets_pkg::S_MARK) && r_out_valid && !i_out_ready
        |=> (r_state == sets_pkg::S_MARK))
        else $error("Controller left the mark state while the output was blocked.");
`endif

endmodule

// ----- rtl/core/sets_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table datapath
// Row of entry cells with per-cell compare, insert/drop shifting, neighbor
// tick compare for the sync marks, result staging and output register.
// ----------------------------------------------------------------------------
module sets_dp #(
    parameter int TABLE_DEPTH = sets_pkg::DEF_TABLE_DEPTH,
    parameter int KIND_COUNT  = sets_pkg::DEF_KIND_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sets_pkg::t_cmd                i_cmd,
    input  logic [sets_pkg::OP_W-1:0]     i_op,
    input  logic [sets_pkg::TICK_W-1:0]   i_tick,
    input  logic [$clog2(KIND_COUNT)-1:0] i_kind,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_slot,
    output logic [sets_pkg::STATUS_W-1:0] o_status,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_position,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_entry_count,
    output logic [sets_pkg::TICK_W-1:0]   o_read_tick,
    output logic [$clog2(KIND_COUNT)-1:0] o_read_kind,
    output logic                          o_read_sync
);

    localparam int SW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = $clog2(KIND_COUNT);
    localparam int TW = sets_pkg::TICK_W;

    // Entry cells; contents above the count are don't-care.
    logic [TW-1:0] r_tick [TABLE_DEPTH];
    logic [KW-1:0] r_kind [TABLE_DEPTH];
    logic          r_sync [TABLE_DEPTH];
    logic [CW-1:0] r_count;

    // Staged result of the executed operation.
    sets_pkg::t_status r_st_status, n_st_status;
    logic [SW-1:0]     r_st_pos, n_st_pos;
    logic [TW-1:0]     r_st_rtick, n_st_rtick;
    logic [KW-1:0]     r_st_rkind, n_st_rkind;
    logic              r_st_rsync, n_st_rsync;

    // Output register.
    sets_pkg::t_status r_o_status;
    logic [SW-1:0]     r_o_pos;
    logic [CW-1:0]     r_o_count;
    logic [TW-1:0]     r_o_rtick;
    logic [KW-1:0]     r_o_rkind;
    logic              r_o_rsync;

    // Per-cell compare vectors.
    logic [TABLE_DEPTH-1:0] cell_live;   // cell holds an entry
    logic [TABLE_DEPTH-1:0] tick_lt;     // live entry with a smaller tick
    logic [TABLE_DEPTH-1:0] ins_at;      // one-hot insertion point
    logic [TABLE_DEPTH-1:0] key_eq;      // live entry equal to tick and kind
    logic [TABLE_DEPTH-1:0] key_first;   // lowest key match, one-hot
    logic [TABLE_DEPTH-1:0] from_first;  // cells at and above the first match
    logic [TABLE_DEPTH-1:0] from_slot;   // cells at and above the slot
    logic [TABLE_DEPTH-1:0] nb_eq;       // cell and the next one share a tick

    logic [SW-1:0]          pos_ins, pos_find;
    logic                   key_hit, slot_ok, is_full;
    logic                   do_ins, do_drop;
    logic [TABLE_DEPTH-1:0] drop_mask;

    // Cell compares at fixed positions.
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cmp
            assign cell_live[g] = CW'(g) < r_count;
            assign tick_lt[g]   = cell_live[g] && (r_tick[g] < i_tick);
            assign key_eq[g]    = cell_live[g] && (r_tick[g] == i_tick) && (r_kind[g] == i_kind);
            assign from_slot[g] = SW'(g) >= i_slot;
            if (g == 0) begin : g_first
                assign ins_at[g] = !tick_lt[g];
            end else begin : g_rest
                assign ins_at[g] = !tick_lt[g] && tick_lt[g-1];
            end
            if (g == TABLE_DEPTH - 1) begin : g_top
                assign nb_eq[g] = 1'b0;
            end else begin : g_low
                assign nb_eq[g] = cell_live[g+1] && (r_tick[g] == r_tick[g+1]);
            end
        end
    endgenerate

    // Lowest match isolated by a two's complement add; mask of it and above.
    assign key_first  = key_eq & (~key_eq + TABLE_DEPTH'(1));
    assign from_first = ~(key_first - TABLE_DEPTH'(1));
    assign key_hit    = |key_eq;
    assign slot_ok    = CW'(i_slot) < r_count;
    assign is_full    = r_count == CW'(TABLE_DEPTH);

    // One-hot to index encoders.
    always_comb begin
        pos_ins  = '0;
        pos_find = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (ins_at[i]) begin
                pos_ins = pos_ins | SW'(i);
            end
            if (key_first[i]) begin
                pos_find = pos_find | SW'(i);
            end
        end
    end

    // Operation decode and result staging values.
    always_comb begin
        do_ins      = 1'b0;
        do_drop     = 1'b0;
        drop_mask   = '0;
        n_st_status = sets_pkg::ST_OK;
        n_st_pos    = '0;
        n_st_rtick  = '0;
        n_st_rkind  = '0;
        n_st_rsync  = 1'b0;
        case (sets_pkg::t_op'(i_op))
            sets_pkg::OP_ADD: begin
                if (is_full) begin
                    n_st_status = sets_pkg::ST_FULL;
                end else begin
                    do_ins   = 1'b1;
                    n_st_pos = pos_ins;
                end
            end
            sets_pkg::OP_DEL_IDX: begin
                if (!slot_ok) begin
                    n_st_status = sets_pkg::ST_MISS;
                end else begin
                    do_drop   = 1'b1;
                    drop_mask = from_slot;
                end
            end
            sets_pkg::OP_DEL_KEY: begin
                if (!key_hit) begin
                    n_st_status = sets_pkg::ST_MISS;
                end else begin
                    do_drop   = 1'b1;
                    drop_mask = from_first;
                end
            end
            sets_pkg::OP_FIND: begin
                if (!key_hit) begin
                    n_st_status = sets_pkg::ST_MISS;
                end else begin
                    n_st_pos = pos_find;
                end
            end
            sets_pkg::OP_READ: begin
                if (!slot_ok) begin
                    n_st_status = sets_pkg::ST_MISS;
                end else begin
                    n_st_rtick = r_tick[i_slot];
                    n_st_rkind = r_kind[i_slot];
                    n_st_rsync = r_sync[i_slot];
                end
            end
            default: begin
            end
        endcase
    end

    // Cell update: insert shifts cells at and above the insertion point up,
    // drop shifts cells at and above the removed one down. Sync marks are
    // refreshed from the neighbor compares while the controller marks.
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            always_ff @(posedge i_clk) begin
                if (i_cmd.exec && do_ins) begin
                    if (ins_at[g]) begin
                        r_tick[g] <= i_tick;
                        r_kind[g] <= i_kind;
                    end else if (g > 0) begin
                        if (!tick_lt[(g > 0) ? g - 1 : 0]) begin
                            r_tick[g] <= r_tick[(g > 0) ? g - 1 : 0];
                            r_kind[g] <= r_kind[(g > 0) ? g - 1 : 0];
                        end
                    end
                end else if (i_cmd.exec && do_drop) begin
                    if (drop_mask[g] && (g < TABLE_DEPTH - 1)) begin
                        r_tick[g] <= r_tick[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                        r_kind[g] <= r_kind[(g < TABLE_DEPTH - 1) ? g + 1 : g];
                    end
                end
                if (i_cmd.mark) begin
                    r_sync[g] <= nb_eq[g] | ((g > 0) ? nb_eq[(g > 0) ? g - 1 : 0] : 1'b0);
                end
            end
        end
    endgenerate

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec && do_ins) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.exec && do_drop) begin
            r_count <= r_count - CW'(1);
        end
    end

    // Result staging and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_st_status <= n_st_status;
            r_st_pos    <= n_st_pos;
            r_st_rtick  <= n_st_rtick;
            r_st_rkind  <= n_st_rkind;
            r_st_rsync  <= n_st_rsync;
        end
        if (i_cmd.load) begin
            r_o_status <= r_st_status;
            r_o_pos    <= r_st_pos;
            r_o_count  <= r_count;
            r_o_rtick  <= r_st_rtick;
            r_o_rkind  <= r_st_rkind;
            r_o_rsync  <= r_st_rsync;
        end
    end

    assign o_status      = r_o_status;
    assign o_position    = r_o_pos;
    assign o_entry_count = r_o_count;
    assign o_read_tick   = r_o_rtick;
    assign o_read_kind   = r_o_rkind;
    assign o_read_sync   = r_o_rsync;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("Entry count changed without an executed operation.");
    a_full_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (i_op == sets_pkg::OP_ADD) && is_full |=> $stable(r_count))
        else $error("Add to a full table changed the entry count.");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event table testbench
// Drives add, remove, find and read requests into the table and checks every
// result against a table model kept in the testbench. A short directed part
// covers the tick extremes, duplicate ticks, misses, out-of-range slots and
// unused op codes. A random part then fills the table to full and drains it
// again several times, under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH          = sets_pkg::DEF_TABLE_DEPTH;
    localparam int KINDS          = sets_pkg::DEF_KIND_COUNT;
    localparam int OPW            = sets_pkg::OP_W;
    localparam int TW             = sets_pkg::TICK_W;
    localparam int STW            = sets_pkg::STATUS_W;
    localparam int ITEMS_PER_RUN  = 500;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // Op codes that the block treats as no operation.
    localparam logic [OPW-1:0] OP_UNUSED_A = 3'd5;
    localparam logic [OPW-1:0] OP_UNUSED_B = 3'd6;
    localparam logic [OPW-1:0] OP_UNUSED_C = 3'd7;

    // One result as seen on the output channel.
    typedef struct {
        logic [STW-1:0] status;
        logic [5:0]     position;
        logic [6:0]     entry_count;
        logic [TW-1:0]  read_tick;
        logic [2:0]     read_kind;
        logic           read_sync;
    } t_table_result;

    // Table model and queue of results still to arrive.
    class event_table_board;
        logic [TW-1:0]  ticks [DEPTH];
        logic [2:0]     kinds [DEPTH];
        int unsigned    fill;
        int unsigned    errors;
        t_table_result  due_q [$];

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // A mark is set when either neighbor holds the same tick.
        function logic sync_at(int unsigned i);
            logic same;
            same = 1'b0;
            if (i > 0 && ticks[i-1] == ticks[i])
                same = 1'b1;
            if (i + 1 < fill && ticks[i+1] == ticks[i])
                same = 1'b1;
            return same;
        endfunction

        // Index of the first entry matching both tick and kind, or -1.
        function int locate(logic [TW-1:0] tick, logic [2:0] kind);
            for (int i = 0; i < fill; i++) begin
                if (ticks[i] == tick && kinds[i] == kind)
                    return i;
            end
            return -1;
        endfunction

        function void drop(int unsigned idx);
            for (int unsigned i = idx; i + 1 < fill; i++) begin
                ticks[i] = ticks[i+1];
                kinds[i] = kinds[i+1];
            end
            fill--;
        endfunction

        // Apply an accepted request to the model and queue its result.
        function void note_request(logic [OPW-1:0] op, logic [TW-1:0] tick,
                                   logic [2:0] kind, logic [5:0] slot);
            t_table_result r;
            int            at;
            r.status    = sets_pkg::ST_OK;
            r.position  = '0;
            r.read_tick = '0;
            r.read_kind = '0;
            r.read_sync = 1'b0;
            case (op)
                sets_pkg::OP_ADD: begin
                    if (fill >= DEPTH) begin
                        r.status = sets_pkg::ST_FULL;
                    end else begin
                        at = fill;
                        for (int i = 0; i < fill; i++) begin
                            if (ticks[i] >= tick) begin
                                at = i;
                                break;
                            end
                        end
                        for (int i = fill; i > at; i--) begin
                            ticks[i] = ticks[i-1];
                            kinds[i] = kinds[i-1];
                        end
                        ticks[at]  = tick;
                        kinds[at]  = kind;
                        fill++;
                        r.position = at[5:0];
                    end
                end
                sets_pkg::OP_DEL_IDX: begin
                    if (slot >= fill)
                        r.status = sets_pkg::ST_MISS;
                    else
                        drop(32'(slot));
                end
                sets_pkg::OP_DEL_KEY: begin
                    at = locate(tick, kind);
                    if (at < 0)
                        r.status = sets_pkg::ST_MISS;
                    else
                        drop(at);
                end
                sets_pkg::OP_FIND: begin
                    at = locate(tick, kind);
                    if (at < 0)
                        r.status = sets_pkg::ST_MISS;
                    else
                        r.position = at[5:0];
                end
                sets_pkg::OP_READ: begin
                    if (slot >= fill) begin
                        r.status = sets_pkg::ST_MISS;
                    end else begin
                        r.read_tick = ticks[slot];
                        r.read_kind = kinds[slot];
                        r.read_sync = sync_at(32'(slot));
                    end
                end
                default: ;
            endcase
            r.entry_count = fill[6:0];
            due_q.push_back(r);
        endfunction

        task report_mismatch(string what, logic [TW-1:0] got, logic [TW-1:0] want);
            $display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
            errors++;
        endtask

        // Compare one accepted result with the oldest expectation.
        task check_result(t_table_result got);
            t_table_result want;
            if (due_q.size() == 0) begin
                report_mismatch("result with nothing pending", '0, '0);
            end else begin
                want = due_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", TW'(got.status), TW'(want.status));
                if (got.position !== want.position)
                    report_mismatch("position", TW'(got.position), TW'(want.position));
                if (got.entry_count !== want.entry_count)
                    report_mismatch("entry_count", TW'(got.entry_count),
                                    TW'(want.entry_count));
                if (got.read_tick !== want.read_tick)
                    report_mismatch("read_tick", got.read_tick, want.read_tick);
                if (got.read_kind !== want.read_kind)
                    report_mismatch("read_kind", TW'(got.read_kind), TW'(want.read_kind));
                if (got.read_sync !== want.read_sync)
                    report_mismatch("read_sync", TW'(got.read_sync), TW'(want.read_sync));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          filling;
    int unsigned quiet_cycles;

    event_table_board board = new();

    sets_in_if  #(.TABLE_DEPTH(DEPTH), .KIND_COUNT(KINDS)) in_if ();
    sets_out_if #(.TABLE_DEPTH(DEPTH), .KIND_COUNT(KINDS)) out_if ();

    sorted_event_table_with_sync_marks #(
        .TABLE_DEPTH(DEPTH),
        .KIND_COUNT (KINDS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver ready, stalling at the rate of the current phase.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_table_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.status      = out_if.status;
            got.position    = out_if.position;
            got.entry_count = out_if.entry_count;
            got.read_tick   = out_if.read_tick;
            got.read_kind   = out_if.read_kind;
            got.read_sync   = out_if.read_sync;
            board.check_result(got);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sorted_event_table_with_sync_marks");
            $finish;
        end
    end

    // Present one request and hold it until the transfer. Called and
    // returns at a falling edge, with valid left high.
    task automatic send_item(logic [OPW-1:0] op, logic [TW-1:0] tick,
                             logic [2:0] kind, logic [5:0] slot);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.event_tick <= tick;
        in_if.event_kind <= kind;
        in_if.slot       <= slot;
        do
            @(posedge i_clk);
        while (!(in_if.valid && in_if.ready));
        board.note_request(op, tick, kind, slot);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has arrived.
    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        while (board.due_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Ticks lean on a small pool so that duplicates and key hits are common.
    function automatic logic [TW-1:0] pick_tick();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return TW'($urandom_range(0, 7));
            4, 5: begin
                if (board.fill > 0)
                    return board.ticks[$urandom_range(0, board.fill - 1)];
                return $urandom();
            end
            6:       return '0;
            7:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Random request, biased toward filling or draining the table.
    task automatic pick_item(output logic [OPW-1:0] op, output logic [TW-1:0] tick,
                             output logic [2:0] kind, output logic [5:0] slot);
        int unsigned roll;
        int unsigned idx;
        if (board.fill == DEPTH && $urandom_range(0, 7) == 0)
            filling = 1'b0;
        else if (board.fill <= 1 && $urandom_range(0, 3) == 0)
            filling = 1'b1;
        roll = $urandom_range(0, 99);
        if (filling) begin
            if (roll < 55)      op = sets_pkg::OP_ADD;
            else if (roll < 65) op = sets_pkg::OP_DEL_IDX;
            else if (roll < 75) op = sets_pkg::OP_DEL_KEY;
            else if (roll < 85) op = sets_pkg::OP_FIND;
            else if (roll < 97) op = sets_pkg::OP_READ;
            else                op = OPW'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
        end else begin
            if (roll < 20)      op = sets_pkg::OP_ADD;
            else if (roll < 50) op = sets_pkg::OP_DEL_IDX;
            else if (roll < 75) op = sets_pkg::OP_DEL_KEY;
            else if (roll < 85) op = sets_pkg::OP_FIND;
            else if (roll < 97) op = sets_pkg::OP_READ;
            else                op = OPW'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
        end
        tick = pick_tick();
        kind = 3'($urandom_range(0, KINDS - 1));
        slot = 6'($urandom_range(0, DEPTH - 1));
        if (board.fill > 0) begin
            idx = $urandom_range(0, board.fill - 1);
            if ($urandom_range(0, 9) < 8)
                slot = idx[5:0];
            if ((op == sets_pkg::OP_DEL_KEY || op == sets_pkg::OP_FIND) &&
                $urandom_range(0, 9) < 7) begin
                tick = board.ticks[idx];
                kind = board.kinds[idx];
            end
        end
    endtask

    // Main sequence.
    initial begin
        logic [OPW-1:0] op;
        logic [TW-1:0]  tick;
        logic [2:0]     kind;
        logic [5:0]     slot;
        idle_pct         = 0;
        stall_pct        = 0;
        filling          = 1'b1;
        quiet_cycles     = 0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.op         <= sets_pkg::OP_ADD;
        in_if.event_tick <= '0;
        in_if.event_kind <= '0;
        in_if.slot       <= '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reads and removes on an empty table miss.
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd0);
        send_item(sets_pkg::OP_DEL_IDX, '0, 3'd0, 6'd0);
        // Tick extremes and a duplicate tick that goes ahead of its twin.
        send_item(sets_pkg::OP_ADD,     32'h0000_0000, 3'd0, 6'd0);
        send_item(sets_pkg::OP_ADD,     32'hFFFF_FFFF, 3'd7, 6'd0);
        send_item(sets_pkg::OP_ADD,     32'h0000_0000, 3'd7, 6'd0);
        send_item(sets_pkg::OP_ADD,     32'h8000_0000, 3'd5, 6'd0);
        send_item(sets_pkg::OP_ADD,     32'h0000_0005, 3'd2, 6'd0);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd0);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd1);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd2);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd4);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd63);
        // Find hits, and a miss on the kind alone.
        send_item(sets_pkg::OP_FIND,    32'h0000_0000, 3'd7, 6'd0);
        send_item(sets_pkg::OP_FIND,    32'h0000_0000, 3'd0, 6'd0);
        send_item(sets_pkg::OP_FIND,    32'h0000_0005, 3'd3, 6'd0);
        // Remove by key must match the kind, not compare the tick to it.
        send_item(sets_pkg::OP_DEL_KEY, 32'h0000_0005, 3'd5, 6'd0);
        send_item(sets_pkg::OP_DEL_KEY, 32'hFFFF_FFFF, 3'd0, 6'd0);
        send_item(sets_pkg::OP_DEL_KEY, 32'hFFFF_FFFF, 3'd7, 6'd0);
        // Remove at index, out of range and in range, then the marks.
        send_item(sets_pkg::OP_DEL_IDX, '0, 3'd0, 6'd63);
        send_item(sets_pkg::OP_DEL_IDX, '0, 3'd0, 6'd0);
        send_item(sets_pkg::OP_READ,    '0, 3'd0, 6'd0);
        // Unused op codes change nothing.
        send_item(OP_UNUSED_A, 32'hFFFF_FFFF, 3'd7, 6'd63);
        send_item(OP_UNUSED_B, 32'h5555_5555, 3'd2, 6'd21);
        send_item(OP_UNUSED_C, 32'hAAAA_AAAA, 3'd5, 6'd42);

        // Random traffic over phases of sender idles and receiver stalls.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            if (ph == 2)
                wait_for_results();
            repeat (ITEMS_PER_RUN) begin
                pick_item(op, tick, kind, slot);
                send_item(op, tick, kind, slot);
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.due_q.size() == 0)
            $display("PASS sorted_event_table_with_sync_marks");
        else
            $display("FAIL sorted_event_table_with_sync_marks");
        $finish;
    end
endmodule
